FILE: rtl/core/sql_statement_splitter_unit_assert.svh
// Assertion macros for the SQL statement splitter.
// Expects signals named clock and reset in the including module.
`ifndef SQL_STATEMENT_SPLITTER_UNIT_ASSERT_SVH
`define SQL_STATEMENT_SPLITTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSS_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("splitter assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define SSS_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("splitter assertion failed: next-cycle check");

`endif

FILE: rtl/core/sss_pkg.sv
// Package for the SQL statement splitter: byte codes, keyword table and helpers.
// No dependencies; used by all modules.
package sss_pkg;

   localparam int WIN_DEPTH = 26;
   localparam int KW_MAX    = WIN_DEPTH + 1;
   localparam int CNT_W     = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   localparam logic [KW_MAX*8-1:0] KW_CREATE_FUNC    = "CREATE FUNCTION";
   localparam logic [KW_MAX*8-1:0] KW_CREATE_OR_FUNC = "CREATE OR REPLACE FUNCTION";
   localparam logic [KW_MAX*8-1:0] KW_CREATE_PROC    = "CREATE PROCEDURE";
   localparam logic [KW_MAX*8-1:0] KW_CREATE_OR_PROC = "CREATE OR REPLACE PROCEDURE";
   localparam logic [KW_MAX*8-1:0] KW_END            = "END";

   localparam int LEN_CREATE_FUNC    = 15;
   localparam int LEN_CREATE_OR_FUNC = 26;
   localparam int LEN_CREATE_PROC    = 16;
   localparam int LEN_CREATE_OR_PROC = 27;
   localparam int LEN_END            = 3;

   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   typedef struct packed {
      logic opener_hit;
      logic closer_hit;
   } match_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   // The keyword's last character sits in the low byte, earlier ones above it,
   // so byte i lines up with window entry i-1.
   function automatic logic kw_hit(input logic [KW_MAX*8-1:0] text, input int len,
                                   input logic [7:0] cur, input window_type win,
                                   input logic [CNT_W-1:0] cnt);
      logic ok;
      ok = (cnt >= CNT_W'(len - 1)) && (upcase(cur) == text[7:0]);
      for (int i = 1; i < KW_MAX; i++) begin
         if (i < len) begin
            ok = ok && (upcase(win[i-1]) == text[i*8 +: 8]);
         end
      end
      return ok;
   endfunction

endpackage

FILE: rtl/core/sss_channels.sv
// Valid/ready channel interfaces for the SQL statement splitter.
// No dependencies; sss_pkg is not used here.
interface sss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       batch_last;

   modport source (output valid, output text_byte, output batch_last, input ready);
   modport sink (input valid, input text_byte, input batch_last, output ready);
endinterface

interface sss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       statement_end;
   logic       statement_blank;

   modport source (output valid, output out_byte, output byte_valid,
                   output statement_end, output statement_blank, input ready);
   modport sink (input valid, input out_byte, input byte_valid,
                 input statement_end, input statement_blank, output ready);
endinterface

FILE: rtl/core/sql_statement_splitter_unit.sv
// Top level of the SQL statement splitter: statement state, window and result register.
// Depends on sss_pkg, sss_channels and sss_keyword_match.
//
//   Channel    Direction   Beat carries
//   req_chan   in          text_byte, batch_last
//   rsp_chan   out         out_byte, byte_valid, statement_end, statement_blank
//
// One byte is accepted per cycle while no result beat is stalled; its result, if any, appears in the cycle after.
// The keyword compare on the 26-byte window is combinational and sets the critical path.
// A new byte is taken in the cycle the held beat leaves; a stalled result beat stalls req.
// Reset is synchronous and clears all statement state.
`include "sql_statement_splitter_unit_assert.svh"

module sql_statement_splitter_unit
   import sss_pkg::*;
(
   input logic      clock,
   input logic      reset,
   sss_req_if.sink  req_chan,
   sss_rsp_if.source rsp_chan
);

   logic             in_quote_ff, in_quote_in;
   logic             in_routine_ff, in_routine_in;
   logic             routine_ended_ff, routine_ended_in;
   logic             skip_next_ff, skip_next_in;
   logic             nonblank_ff, nonblank_in;
   logic [CNT_W-1:0] count_ff, count_in;
   window_type       window_ff, window_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             byte_valid_ff, byte_valid_in;
   logic             stmt_end_ff, stmt_end_in;
   logic             stmt_blank_ff, stmt_blank_in;

   logic             accept;
   logic             has_result;
   logic             term;
   logic             plain;
   logic             routine_now;
   logic             nb;
   logic [7:0]       c;
   logic             last;
   match_type        match;

   assign c      = req_chan.text_byte;
   assign last   = req_chan.batch_last;
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   sss_keyword_match u_match (
      .cur_byte   (c),
      .window     (window_ff),
      .byte_count (count_ff),
      .match      (match)
   );

   always_comb begin
      in_quote_in      = in_quote_ff;
      in_routine_in    = in_routine_ff;
      routine_ended_in = routine_ended_ff;
      skip_next_in     = skip_next_ff;
      nonblank_in      = nonblank_ff;
      count_in         = count_ff;
      window_in        = window_ff;
      out_byte_in      = c;
      byte_valid_in    = 1'b1;
      stmt_end_in      = 1'b0;
      stmt_blank_in    = 1'b0;
      has_result       = 1'b0;
      term             = 1'b0;
      plain            = 1'b0;
      routine_now      = in_routine_ff;
      nb               = nonblank_ff || !is_blank(c);

      if (skip_next_ff) begin
         skip_next_in = 1'b0;
      end else begin
         has_result = 1'b1;
         if (in_quote_ff) begin
            in_quote_in = (c != CH_QUOTE);
         end else if (c == CH_QUOTE) begin
            in_quote_in = 1'b1;
         end else if (c == CH_SEMI && !in_routine_ff && !routine_ended_ff) begin
            term = 1'b1;
         end else if (c == CH_SLASH && routine_ended_ff) begin
            term = 1'b1;
         end else begin
            plain = 1'b1;
         end

         if (plain) begin
            routine_now = in_routine_ff || match.opener_hit;
            in_routine_in = routine_now;
            if (routine_now && match.closer_hit) begin
               in_routine_in    = 1'b0;
               routine_ended_in = 1'b1;
            end
            if (c == CH_CR || c == CH_LF) begin
               out_byte_in = CH_SPACE;
            end
         end

         if (term) begin
            out_byte_in      = '0;
            byte_valid_in    = 1'b0;
            stmt_end_in      = 1'b1;
            stmt_blank_in    = !nonblank_ff;
            in_quote_in      = 1'b0;
            in_routine_in    = 1'b0;
            routine_ended_in = 1'b0;
            nonblank_in      = 1'b0;
            count_in         = '0;
            skip_next_in     = !last;
         end else begin
            window_in   = {window_ff[WIN_DEPTH-2:0], c};
            count_in    = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
            nonblank_in = nb;
            stmt_end_in   = last;
            stmt_blank_in = last && !nb;
         end
      end

      if (last) begin
         in_quote_in      = 1'b0;
         in_routine_in    = 1'b0;
         routine_ended_in = 1'b0;
         skip_next_in     = 1'b0;
         nonblank_in      = 1'b0;
         count_in         = '0;
      end
   end

   always_comb begin
      if (accept && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff      <= 1'b0;
         in_routine_ff    <= 1'b0;
         routine_ended_ff <= 1'b0;
         skip_next_ff     <= 1'b0;
         nonblank_ff      <= 1'b0;
         count_ff         <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            in_quote_ff      <= in_quote_in;
            in_routine_ff    <= in_routine_in;
            routine_ended_ff <= routine_ended_in;
            skip_next_ff     <= skip_next_in;
            nonblank_ff      <= nonblank_in;
            count_ff         <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
      if (accept && has_result) begin
         out_byte_ff   <= out_byte_in;
         byte_valid_ff <= byte_valid_in;
         stmt_end_ff   <= stmt_end_in;
         stmt_blank_ff <= stmt_blank_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.out_byte        = out_byte_ff;
   assign rsp_chan.byte_valid      = byte_valid_ff;
   assign rsp_chan.statement_end   = stmt_end_ff;
   assign rsp_chan.statement_blank = stmt_blank_ff;

   `SSS_ASSERT_NOW(a_term_beat_shape, rsp_chan.valid && !rsp_chan.byte_valid,
                   rsp_chan.statement_end && rsp_chan.out_byte == '0)
   `SSS_ASSERT_NOW(a_blank_only_at_end, rsp_chan.valid && rsp_chan.statement_blank,
                   rsp_chan.statement_end)
   `SSS_ASSERT_NEXT(a_term_sets_skip, accept && term && !last, skip_next_ff)
   `SSS_ASSERT_NEXT(a_result_shows, accept && has_result, rsp_chan.valid)

endmodule

FILE: rtl/core/sss_keyword_match.sv
// Parallel keyword compare of the current byte against the recent-byte window.
// Depends on sss_pkg.
module sss_keyword_match
   import sss_pkg::*;
(
   input  logic [7:0]       cur_byte,
   input  window_type       window,
   input  logic [CNT_W-1:0] byte_count,
   output match_type        match
);

   always_comb begin
      match.opener_hit =
         kw_hit(KW_CREATE_FUNC,    LEN_CREATE_FUNC,    cur_byte, window, byte_count) ||
         kw_hit(KW_CREATE_OR_FUNC, LEN_CREATE_OR_FUNC, cur_byte, window, byte_count) ||
         kw_hit(KW_CREATE_PROC,    LEN_CREATE_PROC,    cur_byte, window, byte_count) ||
         kw_hit(KW_CREATE_OR_PROC, LEN_CREATE_OR_PROC, cur_byte, window, byte_count);
      match.closer_hit = kw_hit(KW_END, LEN_END, cur_byte, window, byte_count);
   end

endmodule

FILE: tb/sv/tb_sql_statement_splitter_unit.sv
// Testbench for sql_statement_splitter_unit: byte streams of SQL text with random idling.
// A scoreboard class predicts each result beat and checks it. Depends on sss_pkg,
// sss_channels and the RTL of the splitter.
module tb_sql_statement_splitter_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import sss_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       statement_end;
      logic       statement_blank;
   } split_beat_type;

   localparam int    ITEM_GOAL     = 750;
   localparam int    DRAIN_LIMIT   = 20000;
   localparam string END_WORD      = "END";
   localparam string routine_heads [4] = '{
      "CREATE FUNCTION", "CREATE OR REPLACE FUNCTION",
      "CREATE PROCEDURE", "CREATE OR REPLACE PROCEDURE"};
   localparam string plain_words [10] = '{
      " a", " 'x;y'", " ''", " 1", "\n", " end", " create function",
      " create procedure", " null", "\r"};
   localparam string routine_words [8] = '{
      " begin", " x := 'a;b';", " end if;", "\r\n", " null;", " '/end'",
      "\tselect 1;", " end;"};

   class splitter_scoreboard;
      bit             in_quote;
      bit             in_routine;
      bit             routine_ended;
      bit             skip_next;
      bit             nonblank_seen;
      logic [7:0]     history [WIN_DEPTH];
      logic [4:0]     stmt_len;
      split_beat_type pending [$];
      int unsigned    errors;
      int unsigned    bytes_taken;

      function new();
         clear_all();
      endfunction

      function void clear_statement();
         in_quote = 0;
         in_routine = 0;
         routine_ended = 0;
         foreach (history[i]) history[i] = 8'h00;
         stmt_len = '0;
         nonblank_seen = 0;
      endfunction

      function void clear_all();
         clear_statement();
         skip_next = 0;
      endfunction

      function logic [7:0] to_upper(logic [7:0] c);
         return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
      endfunction

      function bit is_space(logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
      endfunction

      function bit keyword_done(string kw, logic [7:0] cur);
         int n;
         n = kw.len();
         if (stmt_len < n - 1) return 0;
         if (to_upper(cur) != 8'(kw[n-1])) return 0;
         for (int i = 1; i < n; i++) begin
            if (to_upper(history[i-1]) != 8'(kw[n-1-i])) return 0;
         end
         return 1;
      endfunction

      function void note_byte(logic [7:0] c, bit is_last);
         logic [7:0]     shown;
         bit             term;
         bit             nb;
         split_beat_type beat;
         bytes_taken++;
         if (skip_next) begin
            skip_next = 0;
            if (is_last) clear_all();
            return;
         end
         shown = c;
         term = 0;
         if (in_quote) begin
            if (c == CH_QUOTE) in_quote = 0;
         end else if (c == CH_QUOTE) begin
            in_quote = 1;
         end else if (c == CH_SEMI && !in_routine && !routine_ended) begin
            term = 1;
         end else if (c == CH_SLASH && routine_ended) begin
            routine_ended = 0;
            term = 1;
         end else begin
            foreach (routine_heads[k]) begin
               if (keyword_done(routine_heads[k], c)) in_routine = 1;
            end
            if (in_routine && keyword_done(END_WORD, c)) begin
               in_routine = 0;
               routine_ended = 1;
            end
            if (c == CH_CR || c == CH_LF) shown = CH_SPACE;
         end
         if (term) begin
            beat = '{8'h00, 1'b0, 1'b1, !nonblank_seen};
            clear_statement();
            skip_next = !is_last;
            pending.push_back(beat);
            return;
         end
         nb = nonblank_seen || !is_space(c);
         for (int i = WIN_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = c;
         if (stmt_len != CNT_MAX) stmt_len++;
         nonblank_seen = nb;
         beat = '{shown, 1'b1, is_last, is_last && !nb};
         if (is_last) clear_all();
         pending.push_back(beat);
      endfunction

      function void check_beat(split_beat_type got);
         split_beat_type want;
         if (pending.size() == 0) begin
            $error("unexpected result beat: out_byte %02h byte_valid %0b end %0b blank %0b",
                   got.out_byte, got.byte_valid, got.statement_end, got.statement_blank);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
            errors++;
         end
         if (got.statement_end !== want.statement_end) begin
            $error("statement_end: expected %0b, actual %0b",
                   want.statement_end, got.statement_end);
            errors++;
         end
         if (got.statement_blank !== want.statement_blank) begin
            $error("statement_blank: expected %0b, actual %0b",
                   want.statement_blank, got.statement_blank);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   logic [7:0] pile [$];

   splitter_scoreboard sb = new();

   sss_req_if req_bus ();
   sss_rsp_if rsp_bus ();

   sql_statement_splitter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_beat('{rsp_bus.out_byte, rsp_bus.byte_valid,
                            rsp_bus.statement_end, rsp_bus.statement_blank});
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_byte(req_bus.text_byte, req_bus.batch_last);
         end
      end
   end

   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = idle_len();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   function automatic string mix_case(string s);
      string r;
      byte   c;
      r = s;
      for (int i = 0; i < r.len(); i++) begin
         c = r[i];
         if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1)) begin
            r[i] = c ^ 8'h20;
         end
      end
      return r;
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) pile.push_back(8'(s[i]));
   endfunction

   function automatic void put_blank();
      case ($urandom_range(0, 4))
         0: put_text(" ");
         1: put_text("\t");
         2: put_text("\r");
         3: put_text("\n");
         default: put_text("\r\n");
      endcase
   endfunction

   task automatic send_byte(logic [7:0] b, bit is_last);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.text_byte  <= b;
      req_bus.batch_last <= is_last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_pile(int last_at);
      foreach (pile[i]) send_byte(pile[i], i == last_at);
      pile.delete();
   endtask

   task automatic wait_results();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
         if (waited > DRAIN_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end while (sb.pending.size() != 0);
   endtask

   task automatic build_chunk();
      int k;
      int n;
      case ($urandom_range(0, 99)) inside
         [0:34]: begin
            put_text(mix_case("select"));
            put_blank();
            repeat ($urandom_range(1, 4))
               put_text(mix_case(plain_words[$urandom_range(0, 9)]));
            pile.push_back(CH_SEMI);
            pile.push_back(8'($urandom_range(0, 255)));
         end
         [35:69]: begin
            put_text(mix_case(routine_heads[$urandom_range(0, 3)]));
            put_blank();
            put_text("f()");
            repeat ($urandom_range(0, 4))
               put_text(mix_case(routine_words[$urandom_range(0, 7)]));
            put_blank();
            put_text(mix_case(END_WORD));
            if ($urandom_range(0, 1)) pile.push_back(CH_SEMI);
            if ($urandom_range(0, 2) == 0) put_blank();
            pile.push_back(CH_SLASH);
            pile.push_back(8'($urandom_range(0, 255)));
         end
         [70:79]: begin
            repeat ($urandom_range(0, 3)) put_blank();
            pile.push_back(CH_SEMI);
            pile.push_back(8'($urandom_range(0, 255)));
         end
         [80:91]: begin
            repeat ($urandom_range(1, 12)) pile.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: begin
                  k = $urandom_range(0, 3);
                  n = $urandom_range(1, routine_heads[k].len() - 1);
                  put_text(mix_case(routine_heads[k].substr(0, n - 1)));
               end
               1: put_text("'abc");
               2: put_text(mix_case(END_WORD));
               default: pile.push_back(CH_SLASH);
            endcase
         end
      endcase
   endtask

   initial begin
      int r;
      int last_at;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.text_byte  <= 8'h00;
      req_bus.batch_last <= 1'b0;
      calm = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      put_text("a;\n");
      send_pile(-1);
      pile = '{8'h00, 8'hFF};
      put_text("';';x");
      send_pile(-1);
      put_text("\r\n;z");
      send_pile(-1);
      put_text("b");
      send_pile(0);
      put_text(";");
      send_pile(0);
      put_text("c;d");
      send_pile(2);
      put_text("'e");
      send_pile(1);
      wait_results();

      while (sb.bytes_taken < ITEM_GOAL) begin
         if ($urandom_range(0, 9) == 0) calm = !calm;
         build_chunk();
         r = $urandom_range(0, 99);
         if (r < 8) last_at = pile.size() - 1;
         else if (r < 12) last_at = $urandom_range(0, pile.size() - 1);
         else last_at = -1;
         send_pile(last_at);
         if ($urandom_range(0, 29) == 0) wait_results();
      end

      wait_results();
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d expected result beats never arrived", sb.pending.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
